@@ sv/ruc_pkg.sv @@
// shared types, constants and register codes for the ring uniqueness corner detector
`timescale 1ns / 1ps

package ruc_pkg;

  // pixel and window geometry
  localparam int PIX_W      = 8;
  localparam logic [PIX_W-1:0] PAD_VALUE = 8'hFF;
  localparam int WIN_SIDE   = 5;
  localparam int WIN_HALF   = 2;
  localparam int LINE_COUNT = 4;
  localparam int RING_SIZE  = 8;

  // ring offsets, clockwise from the upper left neighbour
  localparam int RING_DR [RING_SIZE] = '{-1, -1, -1, 0, 1, 1, 1, 0};
  localparam int RING_DC [RING_SIZE] = '{-1, 0, 1, 1, 1, 0, -1, -1};

  // frame limits and field widths
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int CFG_W         = 12;
  localparam int ROW_W         = 12;
  localparam int CTR_ROW_W     = 11;
  localparam int OUT_W         = 11;
  localparam int RST_WIDTH     = 640;
  localparam int RST_HEIGHT    = 480;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // one window column, index is the row within the window
  typedef logic [WIN_SIDE-1:0][PIX_W-1:0] col_t;
  // whole window, index is the column within the window
  typedef col_t [WIN_SIDE-1:0] win_t;

  // control handed to each column cell
  typedef struct packed {
    logic                shift_en;
    logic                col_ok;
    logic [WIN_SIDE-1:0] row_ok;
  } cell_ctl_t;

endpackage

@@ sv/ruc_ram.sv @@
// generic simple dual port ram with registered read, old data on a same address write
`timescale 1ns / 1ps

module ruc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ruc_col_cell.sv @@
// one window column cell: holds five pixels, shifts towards its older neighbour, masks the frame edge
`timescale 1ns / 1ps

module ruc_col_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ruc_pkg::cell_ctl_t ctl,
  input  ruc_pkg::col_t      col_in,
  output ruc_pkg::col_t      col_out,
  output ruc_pkg::col_t      col_vis
);

  import ruc_pkg::*;

  col_t col_r;

  // column storage, padding after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= {WIN_SIDE{PAD_VALUE}};
    end else if (ctl.shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

  // positions outside the frame read as padding
  always_comb begin
    for (int r = 0; r < WIN_SIDE; r++) begin
      col_vis[r] = (ctl.col_ok && ctl.row_ok[r]) ? col_r[r] : PAD_VALUE;
    end
  end

endmodule

@@ sv/ruc_ring_eval.sv @@
// ring uniqueness test over a masked 5x5 window
`timescale 1ns / 1ps

module ruc_ring_eval (
  input  ruc_pkg::win_t win,
  output logic          corner
);

  import ruc_pkg::*;

  logic [RING_SIZE-1:0][PIX_W-1:0]     own;
  logic [RING_SIZE-1:0][RING_SIZE-1:0] neq;
  logic [RING_SIZE-1:0]                ring_diff;

  // ring around the centre
  for (genvar a = 0; a < RING_SIZE; a++) begin : g_own
    assign own[a] = win[WIN_HALF + RING_DC[a]][WIN_HALF + RING_DR[a]];
  end

  // ring around each neighbour against the centre ring
  for (genvar g = 0; g < RING_SIZE; g++) begin : g_nb
    for (genvar a = 0; a < RING_SIZE; a++) begin : g_pos
      localparam int RO = WIN_HALF + RING_DR[g] + RING_DR[a];
      localparam int CO = WIN_HALF + RING_DC[g] + RING_DC[a];
      assign neq[g][a] = (win[CO][RO] != own[a]);
    end
    assign ring_diff[g] = |neq[g];
  end

  // padding centre never counts
  assign corner = (win[WIN_HALF][WIN_HALF] != PAD_VALUE) && (&ring_diff);

endmodule

@@ sv/ring_uniqueness_corner_detector.sv @@
// top level of the ring uniqueness corner detector
// throughput: one pixel beat per clock unless stalled, set by the one line store read per beat
// a result passes the line store and window stage registers on its way to the output register
// a beat reading the column written on the same edge takes its line data from a bypass register
// reset (synchronous): position counters to zero, window to 255, size registers to 640 x 480
// the line store is not cleared; rows above the frame are masked, so no clearing pass is run
`timescale 1ns / 1ps

module ring_uniqueness_corner_detector #(
  parameter int MAX_WIDTH = ruc_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration port
  input  logic                            cfg_we,
  input  logic [ruc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ruc_pkg::CFG_W-1:0]       cfg_data,
  // pixel beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ruc_pkg::PIX_W-1:0]       in_pixel_value,
  input  logic                            in_drain,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ruc_pkg::OUT_W-1:0]       out_corner_row,
  output logic [ruc_pkg::OUT_W-1:0]       out_corner_col,
  output logic                            out_is_corner,
  output logic                            out_frame_end
);

  import ruc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = (WW > CFG_W) ? WW : CFG_W;
  localparam int CXW = WW + 1;
  localparam int CRW = ROW_W + 2;
  localparam int LW  = LINE_COUNT * PIX_W;

  // configuration registers
  logic [CFG_W-1:0] cfg_fw_r;
  logic [CFG_W-1:0] cfg_fh_r;
  logic [XW-1:0]    fw_x;
  logic [XW-1:0]    w_x;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  // input position
  logic [ROW_W-1:0] in_row_r;
  logic [CW-1:0]    in_col_r;
  logic [ROW_W-1:0] in_row_nxt;
  logic [CW-1:0]    in_col_nxt;

  // accept stage
  logic             in_acc;
  logic             col_wrap;
  logic [CW-1:0]    c0;
  logic [ROW_W-1:0] r0;
  logic [WW-1:0]    c1;
  logic [CRW-1:0]   cr_x;
  logic [CW-1:0]    cc_x;
  logic             ctr_neg;
  logic             ctr_beyond;
  logic             has_ctr;
  logic             is_last;

  // line store stage
  logic                 s1_v_r;
  logic                 s1_v_nxt;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [CW-1:0]        s1_col_r;
  logic                 s1_ctr_r;
  logic                 s1_last_r;
  logic [CTR_ROW_W-1:0] s1_cr_r;
  logic [CW-1:0]        s1_cc_r;
  logic                 byp_r;
  logic [LW-1:0]        byp_word_r;
  logic [LW-1:0]        ram_rdata;
  logic [LW-1:0]        line_word;
  logic [LW-1:0]        wr_word;
  col_t                 vec;
  logic [WIN_SIDE-1:0]  row_ok;
  logic [WIN_SIDE-1:0]  col_ok;
  logic                 s1_adv;

  // window stage
  logic                 s2_v_r;
  logic                 s2_v_nxt;
  logic                 s2_ctr_r;
  logic                 s2_last_r;
  logic [CTR_ROW_W-1:0] s2_cr_r;
  logic [CW-1:0]        s2_cc_r;
  logic [WIN_SIDE-1:0]  s2_row_ok_r;
  logic [WIN_SIDE-1:0]  s2_col_ok_r;
  logic                 s2_adv;
  logic                 s2_res;
  logic                 corner;
  win_t                 cell_q;
  win_t                 cell_in;
  win_t                 win_vis;

  // output register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_free;
  logic [OUT_W-1:0]     out_row_r;
  logic [OUT_W-1:0]     out_col_r;
  logic                 out_corner_r;
  logic                 out_end_r;

  // effective frame size, zero taken as one, saturated at the limits
  always_comb begin
    fw_x = XW'(cfg_fw_r);
    if (fw_x == '0) begin
      w_x = XW'(1);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w_x = XW'(MAX_WIDTH);
    end else begin
      w_x = fw_x;
    end
    w_eff = WW'(w_x);
    if (cfg_fh_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (cfg_fh_r > CFG_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(cfg_fh_r);
    end
  end

  // handshake chain
  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = s2_v_r && out_free;
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // position of the beat and of the centre it decides
  always_comb begin
    col_wrap = (WW'(in_col_r) >= w_eff);
    c0       = col_wrap ? '0 : in_col_r;
    r0       = col_wrap ? ROW_W'(in_row_r + ROW_W'(1)) : in_row_r;

    // centre lags two rows and two columns, borrowing from the row above when short
    if (c0 >= CW'(2)) begin
      cr_x = CRW'(r0) - CRW'(2);
      cc_x = CW'(c0 - CW'(2));
    end else if (w_eff >= WW'(2)) begin
      cr_x = CRW'(r0) - CRW'(3);
      cc_x = CW'(WW'(c0) + w_eff - WW'(2));
    end else begin
      cr_x = CRW'(r0) - CRW'(4);
      cc_x = '0;
    end

    ctr_neg    = cr_x[CRW-1];
    ctr_beyond = !ctr_neg && (cr_x[CRW-2:0] >= (CRW-1)'(h_eff));
    has_ctr    = !ctr_neg && !ctr_beyond;
    is_last    = has_ctr && (cr_x[ROW_W-1:0] == ROW_W'(h_eff - ROW_W'(1)))
                 && (WW'(cc_x) == WW'(w_eff - WW'(1)));

    // advance the position, restart after the frame
    c1 = WW'(WW'(c0) + WW'(1));
    if (ctr_beyond || is_last) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (c1 >= w_eff) begin
      in_col_nxt = '0;
      in_row_nxt = ROW_W'(r0 + ROW_W'(1));
    end else begin
      in_col_nxt = CW'(c1);
      in_row_nxt = r0;
    end
  end

  // line store, four rows packed into one word per column
  ruc_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_col_r),
    .wdata(wr_word),
    .re   (in_acc),
    .raddr(c0),
    .rdata(ram_rdata)
  );

  // new window column and the shifted line word
  always_comb begin
    line_word = byp_r ? byp_word_r : ram_rdata;
    for (int i = 0; i < LINE_COUNT; i++) begin
      vec[i] = line_word[i*PIX_W +: PIX_W];
    end
    vec[LINE_COUNT] = s1_pix_r;
    wr_word = {s1_pix_r, line_word[LW-1:PIX_W]};
  end

  // frame edge masks around the centre
  always_comb begin
    row_ok[0] = (s1_cr_r >= CTR_ROW_W'(2));
    row_ok[1] = (s1_cr_r != '0);
    row_ok[2] = 1'b1;
    row_ok[3] = (ROW_W'(ROW_W'(s1_cr_r) + ROW_W'(1)) < h_eff);
    row_ok[4] = (ROW_W'(ROW_W'(s1_cr_r) + ROW_W'(2)) < h_eff);
    col_ok[0] = (s1_cc_r >= CW'(2));
    col_ok[1] = (s1_cc_r != '0);
    col_ok[2] = 1'b1;
    col_ok[3] = (CXW'(CXW'(s1_cc_r) + CXW'(1)) < CXW'(w_eff));
    col_ok[4] = (CXW'(CXW'(s1_cc_r) + CXW'(2)) < CXW'(w_eff));
  end

  // chain of column cells, newest column enters at the top end
  assign cell_in[WIN_SIDE-1] = vec;
  for (genvar c = 0; c < WIN_SIDE - 1; c++) begin : g_link
    assign cell_in[c] = cell_q[c+1];
  end

  for (genvar c = 0; c < WIN_SIDE; c++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift_en = s1_adv;
    assign ctl.col_ok   = s2_col_ok_r[c];
    assign ctl.row_ok   = s2_row_ok_r;
    ruc_col_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .col_in (cell_in[c]),
      .col_out(cell_q[c]),
      .col_vis(win_vis[c])
    );
  end

  ruc_ring_eval u_eval (
    .win   (win_vis),
    .corner(corner)
  );

  assign s2_res = s2_ctr_r && (corner || s2_last_r);

  // next values of the valid flags
  always_comb begin
    s1_v_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    s2_v_nxt = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
    out_valid_nxt = out_free ? (s2_v_r && s2_res) : out_valid_r;
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fw_r    <= CFG_W'(RST_WIDTH);
      cfg_fh_r    <= CFG_W'(RST_HEIGHT);
      in_row_r    <= '0;
      in_col_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            cfg_fw_r <= cfg_data;
          end
          REG_FRAME_HEIGHT: begin
            cfg_fh_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        in_row_r <= in_row_nxt;
        in_col_r <= in_col_nxt;
      end
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // accept stage payload and same-column bypass
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_drain ? PAD_VALUE : in_pixel_value;
      s1_col_r   <= c0;
      s1_ctr_r   <= has_ctr;
      s1_last_r  <= is_last;
      s1_cr_r    <= cr_x[CTR_ROW_W-1:0];
      s1_cc_r    <= cc_x;
      byp_r      <= s1_adv && (s1_col_r == c0);
      byp_word_r <= wr_word;
    end
  end

  // window stage payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ctr_r    <= s1_ctr_r;
      s2_last_r   <= s1_last_r;
      s2_cr_r     <= s1_cr_r;
      s2_cc_r     <= s1_cc_r;
      s2_row_ok_r <= row_ok;
      s2_col_ok_r <= col_ok;
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (s2_adv && s2_res) begin
      out_row_r    <= OUT_W'(s2_cr_r);
      out_col_r    <= OUT_W'(s2_cc_r);
      out_corner_r <= corner;
      out_end_r    <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_corner_row = out_row_r;
  assign out_corner_col = out_col_r;
  assign out_is_corner  = out_corner_r;
  assign out_frame_end  = out_end_r;

endmodule

@@ test/tb_ring_uniqueness_corner_detector.sv @@
// self-checking testbench for the ring uniqueness corner detector
`timescale 1ns / 1ps

module tb_ring_uniqueness_corner_detector;
  import ruc_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             drain;
  } pixel_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    logic             is_corner;
    logic             frame_end;
  } corner_res_t;

  typedef enum logic [1:0] {STYLE_NOISE, STYLE_LEVELS, STYLE_FLAT} pix_style_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel_value = '0;
  logic             in_drain = 1'b0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] out_corner_row;
  logic [OUT_W-1:0] out_corner_col;
  logic             out_is_corner;
  logic             out_frame_end;

  // beats waiting for the driver, results waiting for the block
  pixel_beat_t pixel_beats_q[$];
  corner_res_t corner_due_q[$];

  // predictor state
  logic [PIX_W-1:0] line_rows [LINE_COUNT][MAX_WIDTH_DEF];
  logic [PIX_W-1:0] win_q [WIN_SIDE][WIN_SIDE];
  int               pos_row;
  int               pos_col;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  // run control and bookkeeping
  bit          calm = 1'b0;
  bit          sender_hold = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          stim_count = 0;
  int          beats_taken = 0;
  int          corners_seen = 0;
  int          frames_seen = 0;
  corner_res_t pred_res;
  corner_res_t want_res;

  ring_uniqueness_corner_detector dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .in_drain       (in_drain),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_corner_row (out_corner_row),
    .out_corner_col (out_corner_col),
    .out_is_corner  (out_is_corner),
    .out_frame_end  (out_frame_end)
  );

  always #5 clk = ~clk;

  // frame size as the block uses it, zero taken as one, large values saturated
  function automatic int active_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  task automatic clear_predictor();
    for (int i = 0; i < LINE_COUNT; i++)
      for (int c = 0; c < MAX_WIDTH_DEF; c++) line_rows[i][c] = '0;
    for (int r = 0; r < WIN_SIDE; r++)
      for (int c = 0; c < WIN_SIDE; c++) win_q[r][c] = PAD_VALUE;
    pos_row = 0;
    pos_col = 0;
    width_reg = CFG_W'(RST_WIDTH);
    height_reg = CFG_W'(RST_HEIGHT);
  endtask

  // window pixel at an offset from the centre, padding outside window or frame
  function automatic logic [PIX_W-1:0] window_at(int cr, int cc, int dr, int dc, int w, int h);
    int r;
    int c;
    r = cr + dr;
    c = cc + dc;
    if (dr < -WIN_HALF || dr > WIN_HALF || dc < -WIN_HALF || dc > WIN_HALF) return PAD_VALUE;
    if (r < 0 || c < 0 || r >= h || c >= w) return PAD_VALUE;
    return win_q[dr + WIN_HALF][dc + WIN_HALF];
  endfunction

  // corner when every neighbour's ring differs from the centre's ring somewhere
  function automatic bit ring_is_unique(int cr, int cc, int w, int h);
    logic [PIX_W-1:0] own [RING_SIZE];
    int               differing;
    bit               diff;
    differing = 0;
    if (window_at(cr, cc, 0, 0, w, h) == PAD_VALUE) return 1'b0;
    for (int a = 0; a < RING_SIZE; a++) own[a] = window_at(cr, cc, RING_DR[a], RING_DC[a], w, h);
    for (int g = 0; g < RING_SIZE; g++) begin
      diff = 1'b0;
      for (int a = 0; a < RING_SIZE; a++) begin
        if (window_at(cr, cc, RING_DR[g] + RING_DR[a], RING_DC[g] + RING_DC[a], w, h) != own[a])
          diff = 1'b1;
      end
      if (diff) differing++;
    end
    return differing == RING_SIZE;
  endfunction

  // advance the predictor by one accepted beat, true when a result is due
  function automatic bit predict_corner(input logic [PIX_W-1:0] pix_in, input logic drain_in,
                                        output corner_res_t res);
    int               w;
    int               h;
    int               lin;
    int               centre;
    int               cr;
    int               cc;
    bit               hit;
    bit               last;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] column [WIN_SIDE];
    w = active_width();
    h = active_height();
    pix = drain_in ? PAD_VALUE : pix_in;
    res = '0;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    // column through the line stores, oldest row first
    for (int i = 0; i < LINE_COUNT; i++) column[i] = line_rows[i][pos_col];
    column[LINE_COUNT] = pix;
    for (int i = 0; i < LINE_COUNT; i++) line_rows[i][pos_col] = column[i + 1];
    for (int r = 0; r < WIN_SIDE; r++) begin
      for (int c = 0; c < WIN_SIDE - 1; c++) win_q[r][c] = win_q[r][c + 1];
      win_q[r][WIN_SIDE - 1] = column[r];
    end
    lin = pos_row * w + pos_col;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    // centre trails the newest pixel by two rows and two columns
    if (lin < 2 * w + 2) return 1'b0;
    centre = lin - (2 * w + 2);
    if (centre >= h * w) begin
      pos_row = 0;
      pos_col = 0;
      return 1'b0;
    end
    cr = centre / w;
    cc = centre % w;
    hit = ring_is_unique(cr, cc, w, h);
    last = (centre == h * w - 1);
    if (last) begin
      pos_row = 0;
      pos_col = 0;
    end
    res.row = cr[OUT_W-1:0];
    res.col = cc[OUT_W-1:0];
    res.is_corner = hit;
    res.frame_end = last;
    return hit || last;
  endfunction

  task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // driver: next beat once the current one is taken, random gaps unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_beats_q.size() != 0 && !sender_hold && (calm || $urandom_range(99) >= 22)) begin
        in_valid <= 1'b1;
        in_pixel_value <= pixel_beats_q[0].pix;
        in_drain <= pixel_beats_q[0].drain;
        void'(pixel_beats_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 22);
    end
  end

  // monitor: register writes, accepted pixel beats and result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_predictor();
    end else begin
      if (out_valid && !out_stall) begin
        if (corner_due_q.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d corner %0b end %0b", $time,
                   out_corner_row, out_corner_col, out_is_corner, out_frame_end);
          mismatches++;
        end else begin
          want_res = corner_due_q.pop_front();
          check_field("corner_row", want_res.row, out_corner_row);
          check_field("corner_col", want_res.col, out_corner_col);
          check_field("is_corner", OUT_W'(want_res.is_corner), OUT_W'(out_is_corner));
          check_field("frame_end", OUT_W'(want_res.frame_end), OUT_W'(out_frame_end));
        end
        if (out_is_corner === 1'b1) corners_seen++;
        if (out_frame_end === 1'b1) frames_seen++;
      end
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        beats_taken++;
        if (predict_corner(in_pixel_value, in_drain, pred_res))
          corner_due_q = {corner_due_q, pred_res};
      end
    end
  end

  // append one beat to the driver's queue
  task automatic enqueue_beat(pixel_beat_t beat);
    pixel_beats_q = {pixel_beats_q, beat};
  endtask

  task automatic push_pads(int n);
    pixel_beat_t bt;
    for (int k = 0; k < n; k++) begin
      bt.pix = PIX_W'($urandom_range(255));
      bt.drain = 1'b1;
      enqueue_beat(bt);
      stim_count++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pixel_beats_q.size() != 0 || in_valid || corner_due_q.size() != 0);
  endtask

  // pad out a frame left open by short padding, then let the pipeline settle
  task automatic close_frame();
    int w;
    int h;
    wait_drained();
    if (pos_row != 0 || pos_col != 0) begin
      w = active_width();
      h = active_height();
      push_pads(2 * w + 2 + h * w - (pos_row * w + pos_col));
      wait_drained();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic program_size(logic [CFG_W-1:0] w_val, logic [CFG_W-1:0] h_val);
    close_frame();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w_val;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one frame of pixels in the chosen style, then its padding
  task automatic queue_frame(pix_style_e style, bit short_pad, int drain_pct);
    int               w;
    int               h;
    logic [PIX_W-1:0] lvl_a;
    logic [PIX_W-1:0] lvl_b;
    pixel_beat_t      bt;
    w = active_width();
    h = active_height();
    lvl_a = PIX_W'($urandom_range(255));
    lvl_b = $urandom_range(1) ? PAD_VALUE : PIX_W'($urandom_range(255));
    for (int k = 0; k < w * h; k++) begin
      bt.drain = ($urandom_range(99) < drain_pct);
      case (style)
        STYLE_NOISE:  bt.pix = PIX_W'($urandom_range(255));
        STYLE_LEVELS: bt.pix = $urandom_range(1) ? lvl_a : lvl_b;
        default:      bt.pix = ($urandom_range(99) < 15) ? PIX_W'($urandom_range(255)) : lvl_a;
      endcase
      enqueue_beat(bt);
      stim_count++;
    end
    push_pads(short_pad ? $urandom_range(2 * w + 1) : 2 * w + 2);
  endtask

  // stimulus sequence
  initial begin
    pixel_beat_t  bt;
    logic [7:0]   grid_pix [9];
    int           phase;
    int           w_sel;
    int           h_sel;
    int           r;
    int           half_mark;
    grid_pix = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h5A, 8'h01, 8'h80, 8'hFE, 8'h7F};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero sizes read as a single pixel frame
    program_size('0, '0);
    bt.pix = 8'h00;
    bt.drain = 1'b0;
    enqueue_beat(bt);
    push_pads(4);

    // 3x3 frame with extreme values and a padding beat inside the frame
    program_size(12'd3, 12'd3);
    for (int k = 0; k < 9; k++) begin
      bt.pix = grid_pix[k];
      bt.drain = (k == 4);
      enqueue_beat(bt);
    end
    push_pads(8);

    // random frames, mostly small
    stim_count = 0;
    phase = 0;
    while (stim_count < 2000 || phase <= 6) begin
      r = $urandom_range(99);
      w_sel = (r < 70) ? $urandom_range(12, 1) : (r < 90) ? $urandom_range(40, 13) :
              $urandom_range(2, 1);
      h_sel = ($urandom_range(99) < 90) ? $urandom_range(10, 1) : $urandom_range(30, 11);
      if (phase == 2) begin
        w_sel = 16;
        h_sel = 16;
      end else if (phase == 4) begin
        w_sel = 20;
        h_sel = 12;
      end
      program_size(CFG_W'(w_sel), CFG_W'(h_sel));
      calm = (phase == 2);
      if (phase == 2 || phase == 4 || phase == 6) begin
        queue_frame(STYLE_NOISE, 1'b0, 3);
      end else begin
        repeat ($urandom_range(3, 1))
          queue_frame(pix_style_e'($urandom_range(2)), $urandom_range(99) < 10, 3);
      end
      // long receiver hold-off while pixels keep coming
      if (phase == 4) hold_req++;
      // sender stops mid-frame until every due result is out
      if (phase == 6) begin
        half_mark = pixel_beats_q.size() / 2;
        do @(negedge clk); while (pixel_beats_q.size() > half_mark);
        sender_hold = 1'b1;
        do @(negedge clk); while (in_valid || corner_due_q.size() != 0);
        repeat (5) @(negedge clk);
        sender_hold = 1'b0;
      end
      phase++;
    end

    close_frame();
    repeat (10) @(posedge clk);
    $display("Summary: %0d pixel beats accepted, %0d frames closed, %0d corners reported,",
             beats_taken, frames_seen, corners_seen);
    $display("frame sizes from 1x1 up to 40 wide and 30 tall, with stalls on both sides");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
